// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue with cancel.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_EXTRACT = 2'd1;
  localparam logic [1:0] CMD_CANCEL  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [15:0]        order_id;
    logic signed [15:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [15:0] out_id;
    logic        out_valid;
    logic [1:0]  status;
    logic [4:0]  entry_count;
  } rsp_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the request
    logic cancel_rm;  // drop the first matching entry
    logic emit;       // apply insert/extract and write the result register
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic cancel_pending;  // cancel request with a match still stored
    logic rsp_busy;        // result register holds a result not taken this cycle
  } sts_t;

endpackage

// File: rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: takes one request, runs the cancel sweep, then emits the result.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE: begin
        if (req_valid) begin
          state_next = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (!sts.cancel_pending && !sts.rsp_busy) begin
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  always_comb begin
    req_ready     = 1'b0;
    ctl.load      = 1'b0;
    ctl.cancel_rm = 1'b0;
    ctl.emit      = 1'b0;
    case (state)
      FSM_IDLE: begin
        req_ready = 1'b1;
        ctl.load  = req_valid;
      end
      FSM_EXEC: begin
        // remove matches one per cycle, then wait for a free result slot
        if (sts.cancel_pending) begin
          ctl.cancel_rm = 1'b1;
        end else if (!sts.rsp_busy) begin
          ctl.emit = 1'b1;
        end
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted shift-register chain with parallel compare, request and result regs.
// ----------------------------------------------------------------------------
module spq_datapath
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  req_t req_data,
  input  ctl_t ctl,
  output sts_t sts,
  input  logic rsp_ready,
  output logic rsp_valid,
  output rsp_t rsp_data
);

  localparam int CW = $clog2(DEPTH + 1);

  req_t               cur;
  logic signed [15:0] prio [DEPTH];
  logic [15:0]        ident [DEPTH];
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_after;
  logic               found;
  logic               full;
  logic               do_ins;
  logic               do_ext;
  logic [DEPTH-1:0]   gt;
  logic [DEPTH-1:0]   match;
  logic [DEPTH-1:0]   pre;
  logic [CW+4:0]      cnt_ext;
  rsp_t               res;

  assign full   = (count == CW'(DEPTH));
  assign do_ins = ctl.emit && (cur.cmd == CMD_INSERT) && !full;
  assign do_ext = ctl.emit && (cur.cmd == CMD_EXTRACT) && (count != '0);

  for (genvar g = 0; g < DEPTH; g++) begin : g_slot
    logic               prev_gt;
    logic signed [15:0] dn_p;
    logic [15:0]        dn_id;
    logic signed [15:0] up_p;
    logic [15:0]        up_id;

    assign gt[g]    = (CW'(g) < count) && (cur.priority_req < prio[g]);
    assign match[g] = (CW'(g) < count) && (ident[g] == cur.order_id);
    assign pre[g]   = |match[g:0];

    if (g == 0) begin : g_head
      assign prev_gt = 1'b0;
      assign dn_p    = cur.priority_req;
      assign dn_id   = cur.order_id;
    end else begin : g_body
      assign prev_gt = gt[g-1];
      assign dn_p    = prio[g-1];
      assign dn_id   = ident[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign up_p  = prio[g];
      assign up_id = ident[g];
    end else begin : g_inner
      assign up_p  = prio[g+1];
      assign up_id = ident[g+1];
    end

    always_ff @(posedge clk) begin
      if (do_ins) begin
        // shift right behind the insertion point, drop the new entry in at it
        if (prev_gt) begin
          prio[g]  <= dn_p;
          ident[g] <= dn_id;
        end else if (gt[g] || (CW'(g) == count)) begin
          prio[g]  <= cur.priority_req;
          ident[g] <= cur.order_id;
        end
      end else if (do_ext || (ctl.cancel_rm && pre[g])) begin
        prio[g]  <= up_p;
        ident[g] <= up_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cur <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      found <= 1'b0;
    end else begin
      if (do_ins) begin
        count <= count + 1'b1;
      end else if (do_ext || ctl.cancel_rm) begin
        count <= count - 1'b1;
      end
      if (ctl.load) begin
        found <= 1'b0;
      end else if (ctl.cancel_rm) begin
        found <= 1'b1;
      end
    end
  end

  always_comb begin
    count_after = count;
    if (do_ins) begin
      count_after = count + 1'b1;
    end else if (do_ext) begin
      count_after = count - 1'b1;
    end
  end

  assign cnt_ext = (CW + 5)'(count_after);

  always_comb begin
    res.out_id      = '0;
    res.out_valid   = 1'b0;
    res.status      = ST_OK;
    res.entry_count = cnt_ext[4:0];
    case (cur.cmd)
      CMD_INSERT: begin
        if (full) begin
          res.status = ST_FULL;
        end
      end
      CMD_EXTRACT: begin
        if (count == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_id    = ident[0];
          res.out_valid = 1'b1;
        end
      end
      CMD_CANCEL: begin
        if (!found) begin
          res.status = ST_NOTFOUND;
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      rsp_data <= res;
    end
  end

  assign sts.cancel_pending = (cur.cmd == CMD_CANCEL) && (|match);
  assign sts.rsp_busy       = rsp_valid && !rsp_ready;

endmodule

// File: rtl/sorted_priority_queue_with_cancel.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_with_cancel
// Priority queue of up to DEPTH (priority, id) entries kept in ascending
// order, with insert, extract-minimum and cancel-by-id.
// ----------------------------------------------------------------------------
//  channel  signals                        transfer when
//  req      req_valid req_ready req_data   req_valid && req_ready
//  rsp      rsp_valid rsp_ready rsp_data   rsp_valid && rsp_ready
//
//  Insert, extract and unused codes are captured, then pass once through
//  the compare-and-shift chain. A cancel first has the chain drop its
//  matching entries, one match per cycle, before the result is emitted.
//  A request is taken while the previous result still waits; it holds in
//  the execute step until the result register frees.
//  Reset empties the queue at once; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue_with_cancel
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  ctl_t ctl;
  sts_t sts;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data)
  );

`ifndef SYNTHESIS
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one still executing");

  a_extract_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.out_valid |-> rsp_data.status == ST_OK)
    else $error("extracted id carries a failure status");

  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.out_valid |-> rsp_data.out_id == 16'd0)
    else $error("id present on a non-extract result");
`endif

endmodule
